/* hw/rtl/slm_pkg.sv */
// shared types and constants of the sorted list merge block
`timescale 1ns / 1ps

package slm_pkg;

	// field widths fixed by the item format
	localparam int ValueWidth = 32;
	localparam int PosWidth   = 4;
	localparam int LenWidth   = 5;

	// list_length after reset
	localparam logic [LenWidth-1:0] LenReset = 5'd16;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;    // input transfer: store element, bump its fill count
		logic start;   // merge begins: clear the read pointers
		logic cmp;     // compare list heads, load output register, advance a pointer
		logic clear;   // last result taken: empty both lists
	} ctrl_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic trigger;   // both lists full after the element in transfer
		logic last;      // output register holds the final result
	} dp_status_t;

endpackage

/* hw/rtl/slm_in_if.sv */
// input channel of the sorted list merge block
`timescale 1ns / 1ps

interface slm_in_if;
	import slm_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [ValueWidth-1:0] element_value;
	logic                         from_second;

	modport source (output valid, output element_value, output from_second, input ready);
	modport sink   (input valid, input element_value, input from_second, output ready);
endinterface

/* hw/rtl/slm_out_if.sv */
// result channel of the sorted list merge block
`timescale 1ns / 1ps

interface slm_out_if;
	import slm_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [ValueWidth-1:0] merged_value;
	logic                         came_from_second;
	logic [PosWidth-1:0]          source_position;
	logic                         last_of_merge;

	modport source (output valid, output merged_value, output came_from_second,
		output source_position, output last_of_merge, input ready);
	modport sink   (input valid, input merged_value, input came_from_second,
		input source_position, input last_of_merge, output ready);
endinterface

/* hw/rtl/slm_ram.sv */
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module slm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

/* hw/rtl/slm_datapath.sv */
// datapath: list stores, fill counts, merge pointers and output register
`timescale 1ns / 1ps

module slm_datapath #(
	parameter int MAX_LIST_LEN = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [slm_pkg::LenWidth-1:0]        cfg_wr_data,
	input  logic signed [slm_pkg::ValueWidth-1:0] element_value,
	input  logic                                from_second,
	input  slm_pkg::ctrl_cmd_t                  cmd,
	output slm_pkg::dp_status_t                 status,
	output logic signed [slm_pkg::ValueWidth-1:0] merged_value,
	output logic                                came_from_second,
	output logic [slm_pkg::PosWidth-1:0]        source_position,
	output logic                                last_of_merge
);
	import slm_pkg::*;

	localparam int CW = $clog2(MAX_LIST_LEN + 1);
	localparam int IW = $clog2(MAX_LIST_LEN);
	localparam logic [5:0] MaxLen6 = 6'(MAX_LIST_LEN);

	logic [LenWidth-1:0]   len_q;
	logic [CW-1:0]         eff_len;
	logic [5:0]            len_ext;
	logic [CW-1:0]         f_cnt_q, s_cnt_q, f_cnt_next, s_cnt_next;
	logic                  f_wr, s_wr;
	logic                  both_full;
	logic [CW-1:0]         i_q, j_q;
	logic [ValueWidth-1:0] f_rd, s_rd;
	logic                  take_first;
	logic [CW:0]           pos_sum;
	logic                  last_now;
	logic signed [ValueWidth-1:0] value_q;
	logic                  src_q;
	logic [PosWidth-1:0]   pos_q;
	logic                  last_q;

	// length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LenReset;
		end else if (cfg_wr_en) begin
			len_q <= cfg_wr_data;
		end
	end

	// effective length: zero acts as one, clamp at store depth
	always_comb begin
		len_ext = {1'b0, len_q};
		if (len_ext == 6'd0) begin
			eff_len = CW'(1);
		end else if (len_ext > MaxLen6) begin
			eff_len = CW'(MAX_LIST_LEN);
		end else begin
			eff_len = CW'(len_ext);
		end
	end

	// store writes and next fill counts for an input transfer
	always_comb begin
		f_wr       = cmd.load && !from_second && (f_cnt_q < eff_len);
		s_wr       = cmd.load && from_second && (s_cnt_q < eff_len);
		f_cnt_next = f_wr ? f_cnt_q + CW'(1) : f_cnt_q;
		s_cnt_next = s_wr ? s_cnt_q + CW'(1) : s_cnt_q;
		both_full  = (f_cnt_next >= eff_len) && (s_cnt_next >= eff_len);
	end

	// fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_cnt_q <= '0;
			s_cnt_q <= '0;
		end else if (cmd.clear) begin
			f_cnt_q <= '0;
			s_cnt_q <= '0;
		end else begin
			f_cnt_q <= f_cnt_next;
			s_cnt_q <= s_cnt_next;
		end
	end

	slm_ram #(.WIDTH(ValueWidth), .DEPTH(MAX_LIST_LEN)) u_first_ram (
		.clk     (clk),
		.wr_en   (f_wr),
		.wr_addr (f_cnt_q[IW-1:0]),
		.wr_data (element_value),
		.rd_addr (i_q[IW-1:0]),
		.rd_data (f_rd)
	);

	slm_ram #(.WIDTH(ValueWidth), .DEPTH(MAX_LIST_LEN)) u_second_ram (
		.clk     (clk),
		.wr_en   (s_wr),
		.wr_addr (s_cnt_q[IW-1:0]),
		.wr_data (element_value),
		.rd_addr (j_q[IW-1:0]),
		.rd_data (s_rd)
	);

	// head compare, first list wins ties
	always_comb begin
		if (i_q >= eff_len) begin
			take_first = 1'b0;
		end else if (j_q >= eff_len) begin
			take_first = 1'b1;
		end else begin
			take_first = $signed(f_rd) <= $signed(s_rd);
		end
		pos_sum  = {1'b0, i_q} + {1'b0, j_q} + (CW+1)'(1);
		last_now = pos_sum == {eff_len, 1'b0};
	end

	// merge pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
		end else if (cmd.start) begin
			i_q <= '0;
			j_q <= '0;
		end else if (cmd.cmp) begin
			if (take_first) begin
				i_q <= i_q + CW'(1);
			end else begin
				j_q <= j_q + CW'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			value_q <= take_first ? $signed(f_rd) : $signed(s_rd);
			src_q   <= !take_first;
			pos_q   <= take_first ? PosWidth'(i_q) : PosWidth'(j_q);
			last_q  <= last_now;
		end
	end

	assign status           = '{trigger: both_full, last: last_q};
	assign merged_value     = value_q;
	assign came_from_second = src_q;
	assign source_position  = pos_q;
	assign last_of_merge    = last_q;

endmodule

/* hw/rtl/slm_controller.sv */
// controller: load, fetch, compare and emit sequencing
`timescale 1ns / 1ps

module slm_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  slm_pkg::dp_status_t status,
	output slm_pkg::ctrl_cmd_t  cmd
);
	import slm_pkg::*;

	localparam logic [1:0] StLoad = 2'd0;
	localparam logic [1:0] StRead = 2'd1;
	localparam logic [1:0] StCmp  = 2'd2;
	localparam logic [1:0] StEmit = 2'd3;

	logic [1:0] state_q, state_next;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StLoad;
		end else begin
			state_q <= state_next;
		end
	end

	// next state and commands
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		unique case (state_q)
			StLoad: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (status.trigger) begin
						cmd.start  = 1'b1;
						state_next = StRead;
					end
				end
			end
			StRead: begin
				state_next = StCmp;
			end
			StCmp: begin
				cmd.cmp    = 1'b1;
				state_next = StEmit;
			end
			StEmit: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (status.last) begin
						cmd.clear  = 1'b1;
						state_next = StLoad;
					end else begin
						state_next = StCmp;
					end
				end
			end
			default: begin
				state_next = StLoad;
			end
		endcase
	end

endmodule

/* hw/rtl/sorted_list_merge_by_rank.sv */
// top level of the sorted list merge block
//
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    element_value, from_second
//  out_ch   out  valid/ready    merged_value, came_from_second, source_position,
//                               last_of_merge
//  cfg      in   cfg_wr_en      cfg_wr_data (list_length)
//
// loading takes one element transfer per cycle, only while in the load state
// the merge gives 2*n results, each through the compare and emit states, after a read
// state for the registered read of the two list rams feeding the head compare
// reset clears the fill counts and the controller; list_length resets to 16
// a stalled result holds the output register; no element is taken during a merge
`timescale 1ns / 1ps

module sorted_list_merge_by_rank #(
	parameter int MAX_LIST_LEN = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	slm_in_if.sink                       in_ch,
	slm_out_if.source                    out_ch,
	input  logic                         cfg_wr_en,
	input  logic [slm_pkg::LenWidth-1:0] cfg_wr_data
);
	import slm_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// sequencing
	slm_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// storage and merge datapath
	slm_datapath #(.MAX_LIST_LEN(MAX_LIST_LEN)) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.element_value    (in_ch.element_value),
		.from_second      (in_ch.from_second),
		.cmd              (cmd),
		.status           (status),
		.merged_value     (out_ch.merged_value),
		.came_from_second (out_ch.came_from_second),
		.source_position  (out_ch.source_position),
		.last_of_merge    (out_ch.last_of_merge)
	);

endmodule
